/* sv/ssa_pkg.sv */
`timescale 1ns / 1ps
// ssa_pkg: shared types and codes for the slab slot allocator.
// No dependencies; used by the channel interfaces and the top level.
package ssa_pkg;

    // Request kind
    typedef enum logic {
        KIND_ALLOC = 1'b0,
        KIND_FREE  = 1'b1
    } t_kind;

    // Response status
    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_NO_SLAB = 2'd1,
        STAT_REJECT  = 2'd2
    } t_status;

    localparam int unsigned SLAB_FIELD_W = 3;
    localparam int unsigned SLOT_FIELD_W = 5;

endpackage

/* sv/ssa_req_if.sv */
`timescale 1ns / 1ps
// ssa_req_if: request channel (valid/ready plus request payload).
// Depends on ssa_pkg.
interface ssa_req_if import ssa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_kind                   kind;
    logic [SLAB_FIELD_W-1:0] slab_number;
    logic [SLOT_FIELD_W-1:0] slot_number;

    modport source (output valid, kind, slab_number, slot_number, input ready);
    modport sink   (input valid, kind, slab_number, slot_number, output ready);
endinterface

/* sv/ssa_rsp_if.sv */
`timescale 1ns / 1ps
// ssa_rsp_if: response channel (valid/ready plus response payload).
// Depends on ssa_pkg.
interface ssa_rsp_if import ssa_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic [SLAB_FIELD_W-1:0] granted_slab;
    logic [SLOT_FIELD_W-1:0] granted_slot;

    modport source (output valid, status, granted_slab, granted_slot, input ready);
    modport sink   (input valid, status, granted_slab, granted_slot, output ready);
endinterface

/* sv/ssa_ram.sv */
`timescale 1ns / 1ps
// ssa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/slab_slot_allocator.sv */
`timescale 1ns / 1ps
// slab_slot_allocator: one transaction in process at a time. Free: F_CHK, DONE.
//   Allocate with no slab left: A_NEW, DONE; from the current slab: A_CNT, A_POP, DONE,
//   plus SCAN when the slab empties and the later slabs' free counts are walked through
//   the count RAM read port; opening a slab: A_NEW, OPEN (a stack RAM write per slot),
//   OPEN_FIN, DONE. A response held by o_rsp.ready adds its wait to the next request.
// Reset (sync, active low) clears the sequencer, slab bookkeeping and response valid.
// RAMs are not cleared: counts beyond r_opened are never used.
module slab_slot_allocator import ssa_pkg::*; #(
    parameter int NUM_SLABS      = 8,
    parameter int SLOTS_PER_SLAB = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ssa_req_if.sink   i_req,
    ssa_rsp_if.source o_rsp
);
    // Widths derived from the geometry
    localparam int SW    = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;   // slab index
    localparam int OPW   = $clog2(NUM_SLABS + 1);                     // opened count
    localparam int IW    = $clog2(SLOTS_PER_SLAB);                    // slot index
    localparam int CNW   = $clog2(SLOTS_PER_SLAB + 1);                // free count
    localparam int DEPTH = NUM_SLABS * SLOTS_PER_SLAB;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;           // stack address
    localparam int XW    = 7;                                          // compare width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_CNT,     // count of current slab arrives
        ST_A_POP,     // popped slot arrives
        ST_A_NEW,     // no current slab: open next or fail
        ST_OPEN,      // write initial stack, one entry per cycle
        ST_OPEN_FIN,  // set count, grant slot 0
        ST_SCAN,      // search later slabs for free slots
        ST_F_CHK,     // free: validate and push
        ST_DONE       // hand result to output register
    } t_state;

    // Stack address: slab * SLOTS_PER_SLAB + index
    function automatic logic [AW-1:0] stk_addr(input logic [SW-1:0] slab,
                                               input logic [IW-1:0] idx);
        return AW'(slab) * AW'(SLOTS_PER_SLAB) + AW'(idx);
    endfunction

    t_state                r_state, n_state;
    t_kind                 r_kind, n_kind;
    logic [SLAB_FIELD_W-1:0] r_slab_in, n_slab_in;
    logic [SLOT_FIELD_W-1:0] r_slot_in, n_slot_in;
    logic [OPW-1:0]        r_opened, n_opened;
    logic [SW-1:0]         r_cur, n_cur;
    logic                  r_cur_valid, n_cur_valid;
    logic [IW-1:0]         r_idx, n_idx;          // open sweep index
    logic [CNW-1:0]        r_cnt, n_cnt;          // count after pop
    logic [OPW-1:0]        r_scan, n_scan;        // next slab to read in scan
    logic [SW-1:0]         r_chk_idx, n_chk_idx;  // slab whose count is arriving
    logic                  r_pend, n_pend;
    t_status               r_res_status, n_res_status;
    logic [SLAB_FIELD_W-1:0] r_res_slab, n_res_slab;
    logic [SLOT_FIELD_W-1:0] r_res_slot, n_res_slot;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [SLAB_FIELD_W-1:0] r_out_slab, n_out_slab;
    logic [SLOT_FIELD_W-1:0] r_out_slot, n_out_slot;

    // RAM ports
    logic           cnt_we;
    logic [SW-1:0]  cnt_waddr, cnt_raddr;
    logic [CNW-1:0] cnt_wdata, cnt_rdata;
    logic           stk_we;
    logic [AW-1:0]  stk_waddr, stk_raddr;
    logic [IW-1:0]  stk_wdata, stk_rdata;

    // Free-request checks on the latched fields
    logic           free_bad;
    logic [SW-1:0]  slab_idx;

    ssa_ram #(.WIDTH(CNW), .DEPTH(NUM_SLABS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_rdata)
    );

    ssa_ram #(.WIDTH(IW), .DEPTH(DEPTH)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign slab_idx = SW'(r_slab_in);
    // Not opened, out of range, or slab already full
    assign free_bad = (XW'(r_slab_in) >= XW'(r_opened))
                   || (XW'(r_slab_in) >= XW'(NUM_SLABS))
                   || (XW'(r_slot_in) >= XW'(SLOTS_PER_SLAB))
                   || (XW'(cnt_rdata) >= XW'(SLOTS_PER_SLAB));

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_slab_in    = r_slab_in;
        n_slot_in    = r_slot_in;
        n_opened     = r_opened;
        n_cur        = r_cur;
        n_cur_valid  = r_cur_valid;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_scan       = r_scan;
        n_chk_idx    = r_chk_idx;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_res_slab   = r_res_slab;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_slab   = r_out_slab;
        n_out_slot   = r_out_slot;

        cnt_we    = 1'b0;
        cnt_waddr = r_cur;
        cnt_wdata = '0;
        cnt_raddr = r_cur;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_raddr = '0;

        unique case (r_state)
            ST_IDLE: begin
                // Count read is issued speculatively in the accept cycle
                cnt_raddr = (i_req.kind == KIND_ALLOC) ? r_cur : SW'(i_req.slab_number);
                if (i_req.valid) begin
                    n_kind       = i_req.kind;
                    n_slab_in    = i_req.slab_number;
                    n_slot_in    = i_req.slot_number;
                    n_res_status = STAT_OK;
                    n_res_slab   = '0;
                    n_res_slot   = '0;
                    if (i_req.kind == KIND_FREE) begin
                        n_state = ST_F_CHK;
                    end else if (r_cur_valid) begin
                        n_state = ST_A_CNT;
                    end else begin
                        n_state = ST_A_NEW;
                    end
                end
            end
            ST_A_CNT: begin
                if (cnt_rdata == '0) begin
                    // empty current slab: drop it and open a new one
                    n_cur_valid = 1'b0;
                    n_state     = ST_A_NEW;
                end else begin
                    n_cnt     = cnt_rdata - CNW'(1);
                    cnt_we    = 1'b1;
                    cnt_waddr = r_cur;
                    cnt_wdata = cnt_rdata - CNW'(1);
                    stk_raddr = stk_addr(r_cur, IW'(cnt_rdata - CNW'(1)));
                    n_state   = ST_A_POP;
                end
            end
            ST_A_POP: begin
                n_res_slab = SLAB_FIELD_W'(r_cur);
                n_res_slot = SLOT_FIELD_W'(stk_rdata);
                if (r_cnt == '0) begin
                    n_cur_valid = 1'b0;
                    n_scan      = OPW'(r_cur) + OPW'(1);
                    n_pend      = 1'b0;
                    n_state     = ST_SCAN;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                cnt_raddr = SW'(r_scan);
                if (r_pend && cnt_rdata != '0) begin
                    n_cur       = r_chk_idx;
                    n_cur_valid = 1'b1;
                    n_state     = ST_DONE;
                end else if (r_scan < r_opened) begin
                    n_chk_idx = SW'(r_scan);
                    n_pend    = 1'b1;
                    n_scan    = r_scan + OPW'(1);
                end else begin
                    n_state = ST_DONE;   // no later slab has free slots
                end
            end
            ST_A_NEW: begin
                if (XW'(r_opened) >= XW'(NUM_SLABS)) begin
                    n_res_status = STAT_NO_SLAB;
                    n_state      = ST_DONE;
                end else begin
                    n_idx   = '0;
                    n_state = ST_OPEN;
                end
            end
            ST_OPEN: begin
                // stack bottom to top holds SLOTS_PER_SLAB-1 down to 0
                stk_we    = 1'b1;
                stk_waddr = stk_addr(SW'(r_opened), r_idx);
                stk_wdata = IW'(SLOTS_PER_SLAB - 1) - r_idx;
                n_idx     = r_idx + IW'(1);
                if (r_idx == IW'(SLOTS_PER_SLAB - 1)) begin
                    n_state = ST_OPEN_FIN;
                end
            end
            ST_OPEN_FIN: begin
                // top of a fresh stack is slot 0; count never reaches zero here
                cnt_we      = 1'b1;
                cnt_waddr   = SW'(r_opened);
                cnt_wdata   = CNW'(SLOTS_PER_SLAB - 1);
                n_cur       = SW'(r_opened);
                n_cur_valid = 1'b1;
                n_opened    = r_opened + OPW'(1);
                n_res_slab  = SLAB_FIELD_W'(r_opened);
                n_res_slot  = '0;
                n_state     = ST_DONE;
            end
            ST_F_CHK: begin
                if (free_bad) begin
                    n_res_status = STAT_REJECT;
                end else begin
                    stk_we    = 1'b1;
                    stk_waddr = stk_addr(slab_idx, IW'(cnt_rdata));
                    stk_wdata = IW'(r_slot_in);
                    cnt_we    = 1'b1;
                    cnt_waddr = slab_idx;
                    cnt_wdata = cnt_rdata + CNW'(1);
                    if (!r_cur_valid || XW'(r_slab_in) < XW'(r_cur)) begin
                        n_cur       = slab_idx;
                        n_cur_valid = 1'b1;
                    end
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_slab   = r_res_slab;
                    n_out_slot   = r_res_slot;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_opened    <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_opened    <= n_opened;
            r_cur       <= n_cur;
            r_cur_valid <= n_cur_valid;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_kind       <= n_kind;
        r_slab_in    <= n_slab_in;
        r_slot_in    <= n_slot_in;
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_scan       <= n_scan;
        r_chk_idx    <= n_chk_idx;
        r_res_status <= n_res_status;
        r_res_slab   <= n_res_slab;
        r_res_slot   <= n_res_slot;
        r_out_status <= n_out_status;
        r_out_slab   <= n_out_slab;
        r_out_slot   <= n_out_slot;
    end

    assign i_req.ready        = (r_state == ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.granted_slab = r_out_slab;
    assign o_rsp.granted_slot = r_out_slot;

    // Opened slab count never passes the slab budget
    a_opened_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_opened) <= XW'(NUM_SLABS))
        else $error("slabs opened beyond NUM_SLABS");

    // A current slab is always one that has been opened
    a_cur_opened: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (XW'(r_cur) < XW'(r_opened)))
        else $error("current slab not opened");

    // Failed or free transactions carry zero slab and slot
    a_zero_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (r_res_status != STAT_OK || r_kind == KIND_FREE))
        |-> (r_res_slab == '0 && r_res_slot == '0))
        else $error("nonzero grant on non-allocate result");

    // An accepted request leaves idle on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request accepted while busy");
endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking bench for slab_slot_allocator: a directed table first, then random
// allocate/return traffic, checked against an in-bench mirror of the slab bookkeeping.
// Depends on ssa_pkg, ssa_req_if, ssa_rsp_if and the allocator RTL.
module tb_top;
    import ssa_pkg::*;

    localparam int NUM_SLABS      = 8;
    localparam int SLOTS_PER_SLAB = 32;
    localparam int RANDOM_ITEMS   = 750;
    localparam int QUIET_FROM     = 650;   // no gaps on either side from here on
    localparam int TAIL_CYCLES    = 60;
    localparam int STALL_LIMIT    = 3000;  // cycles with no transaction on either channel
    localparam int LONG_HOLD      = 300;

    typedef struct packed {
        t_status    status;
        logic [2:0] slab;
        logic [4:0] slot;
    } t_grant;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] slab;
        logic [4:0] slot;
        logic       typed;   // want holds a hand-written result
        t_grant     want;
    } t_req_row;

    typedef struct packed {
        logic [2:0] slab;
        logic [4:0] slot;
    } t_slot_ref;

    typedef enum int {
        PH_FILL    = 0,
        PH_EXHAUST = 1,
        PH_DRAIN   = 2,
        PH_MIXED   = 3
    } t_phase;

    // Directed table. Stack after open is 31..0 bottom to top, so pops start at slot 0.
    localparam t_req_row DIRECTED [20] = '{
        {KIND_FREE,  3'd0, 5'd0,  1'b1, STAT_REJECT, 3'd0, 5'd0},   // nothing opened yet
        {KIND_FREE,  3'd7, 5'd31, 1'b1, STAT_REJECT, 3'd0, 5'd0},
        {KIND_ALLOC, 3'd5, 5'd17, 1'b1, STAT_OK,     3'd0, 5'd0},   // opens slab 0
        {KIND_ALLOC, 3'd0, 5'd0,  1'b1, STAT_OK,     3'd0, 5'd1},
        {KIND_ALLOC, 3'd7, 5'd31, 1'b1, STAT_OK,     3'd0, 5'd2},
        {KIND_FREE,  3'd0, 5'd31, 1'b1, STAT_OK,     3'd0, 5'd0},   // slot 31 still free: pushed again
        {KIND_ALLOC, 3'd2, 5'd9,  1'b1, STAT_OK,     3'd0, 5'd31},
        {KIND_FREE,  3'd0, 5'd1,  1'b1, STAT_OK,     3'd0, 5'd0},
        {KIND_FREE,  3'd0, 5'd0,  1'b1, STAT_OK,     3'd0, 5'd0},
        {KIND_FREE,  3'd0, 5'd2,  1'b1, STAT_OK,     3'd0, 5'd0},   // slab 0 full again
        {KIND_FREE,  3'd0, 5'd5,  1'b1, STAT_REJECT, 3'd0, 5'd0},   // return into a full slab
        {KIND_FREE,  3'd1, 5'd0,  1'b1, STAT_REJECT, 3'd0, 5'd0},   // slab not opened
        {KIND_ALLOC, 3'd0, 5'd0,  1'b1, STAT_OK,     3'd0, 5'd2},
        {KIND_ALLOC, 3'd1, 5'd3,  1'b0, STAT_OK,     3'd0, 5'd0},
        {KIND_ALLOC, 3'd6, 5'd24, 1'b0, STAT_OK,     3'd0, 5'd0},
        {KIND_ALLOC, 3'd3, 5'd12, 1'b0, STAT_OK,     3'd0, 5'd0},
        {KIND_ALLOC, 3'd4, 5'd8,  1'b0, STAT_OK,     3'd0, 5'd0},
        {KIND_FREE,  3'd0, 5'd30, 1'b0, STAT_OK,     3'd0, 5'd0},
        {KIND_FREE,  3'd0, 5'd16, 1'b0, STAT_OK,     3'd0, 5'd0},
        {KIND_FREE,  3'd3, 5'd16, 1'b1, STAT_REJECT, 3'd0, 5'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ssa_req_if req_ch ();
    ssa_rsp_if rsp_ch ();

    slab_slot_allocator #(
        .NUM_SLABS      (NUM_SLABS),
        .SLOTS_PER_SLAB (SLOTS_PER_SLAB)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mirror of the slab bookkeeping
    logic [5:0]  slab_free_cnt [NUM_SLABS];
    logic [4:0]  slab_stack    [NUM_SLABS][SLOTS_PER_SLAB];
    int unsigned slabs_open;
    logic [2:0]  cur_slab;
    bit          cur_ok;

    t_grant    expected_grants [$];
    t_slot_ref held_slots [$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        gaps_on        = 1'b1;
    bit        quiet          = 1'b0;
    bit        hold_request   = 1'b0;
    t_grant    want_now;

    // Next grant for one request; updates the mirror.
    function automatic t_grant grant_for(t_kind kind, logic [2:0] slab, logic [4:0] slot);
        t_grant     g;
        logic [5:0] left;
        int         s;
        g.status = STAT_OK;
        g.slab   = '0;
        g.slot   = '0;
        if (kind == KIND_ALLOC) begin
            if (cur_ok && slab_free_cnt[cur_slab] == 0)
                cur_ok = 1'b0;
            if (!cur_ok) begin
                if (slabs_open >= NUM_SLABS) begin
                    g.status = STAT_NO_SLAB;
                    return g;
                end
                for (s = 0; s < SLOTS_PER_SLAB; s++)
                    slab_stack[slabs_open][s] = 5'(SLOTS_PER_SLAB - 1 - s);
                slab_free_cnt[slabs_open] = 6'(SLOTS_PER_SLAB);
                cur_slab = 3'(slabs_open);
                cur_ok   = 1'b1;
                slabs_open++;
            end
            left = slab_free_cnt[cur_slab] - 6'd1;
            slab_free_cnt[cur_slab] = left;
            g.slab = cur_slab;
            g.slot = slab_stack[cur_slab][left[4:0]];
            if (left == 0) begin
                // slab ran dry: first later opened slab with room takes over
                cur_ok = 1'b0;
                for (s = int'(cur_slab) + 1; s < int'(slabs_open); s++) begin
                    if (slab_free_cnt[s] != 0) begin
                        cur_slab = 3'(s);
                        cur_ok   = 1'b1;
                        break;
                    end
                end
            end
        end else if (int'(slab) >= int'(slabs_open) ||
                     int'(slab_free_cnt[slab]) >= SLOTS_PER_SLAB) begin
            g.status = STAT_REJECT;
        end else begin
            slab_stack[slab][slab_free_cnt[slab][4:0]] = slot;
            slab_free_cnt[slab] = slab_free_cnt[slab] + 6'd1;
            if (!cur_ok || slab < cur_slab) begin
                cur_slab = slab;
                cur_ok   = 1'b1;
            end
        end
        return g;
    endfunction

    // Offer one request, wait for it to be taken, record what must come back.
    task automatic issue(input t_req_row r, output t_grant g);
        t_slot_ref h;
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= r.kind;
        req_ch.slab_number <= r.slab;
        req_ch.slot_number <= r.slot;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        g = grant_for(r.kind, r.slab, r.slot);
        expected_grants.push_back(r.typed ? r.want : g);
        if (r.kind == KIND_ALLOC && g.status == STAT_OK) begin
            h = {g.slab, g.slot};
            held_slots.push_back(h);
        end
    endtask

    task automatic maybe_gap();
        if (gaps_on && !quiet && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Request side
    initial begin
        int        n_rand;
        int        n_phase;
        int        p;
        int        roll;
        int        pick;
        int        noise_pct;
        int        free_pct;
        int        no_slab_seen;
        bit        phase_done;
        t_phase    ph;
        t_req_row  r;
        t_grant    g;
        t_slot_ref h;

        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_ALLOC;
        req_ch.slab_number = '0;
        req_ch.slot_number = '0;
        i_rst_n            = 1'b0;
        for (int s = 0; s < NUM_SLABS; s++)
            slab_free_cnt[s] = '0;
        slabs_open = 0;
        cur_slab   = '0;
        cur_ok     = 1'b0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 20; i++) begin
            issue(DIRECTED[i], g);
            maybe_gap();
        end

        hold_request = 1'b1;   // response side now stalls long enough to back up requests
        n_rand = 0;
        p      = 0;
        while (n_rand < RANDOM_ITEMS) begin
            ph           = t_phase'(p % 4);
            gaps_on      = (p % 3) != 2;
            n_phase      = 0;
            no_slab_seen = 0;
            phase_done   = 1'b0;
            case (ph)
                PH_FILL:    begin noise_pct = 5; free_pct = 8;  end
                PH_EXHAUST: begin noise_pct = 2; free_pct = 0;  end
                PH_DRAIN:   begin noise_pct = 8; free_pct = 75; end
                default:    begin noise_pct = 8; free_pct = 45; end
            endcase
            while (n_rand < RANDOM_ITEMS && !phase_done) begin
                quiet   = n_rand >= QUIET_FROM;
                r.kind  = KIND_ALLOC;
                r.slab  = 3'($urandom);
                r.slot  = 5'($urandom);
                r.typed = 1'b0;
                r.want  = '0;
                roll    = $urandom_range(0, 99);
                if (roll < noise_pct) begin
                    r.kind = KIND_FREE;   // arbitrary return: reject, double return or valid
                end else if (roll < noise_pct + free_pct && held_slots.size() != 0) begin
                    pick = $urandom_range(0, held_slots.size() - 1);
                    h    = held_slots[pick];
                    held_slots.delete(pick);
                    r.kind = KIND_FREE;
                    r.slab = h.slab;
                    r.slot = h.slot;
                end
                issue(r, g);
                n_rand++;
                n_phase++;
                if (g.status == STAT_NO_SLAB)
                    no_slab_seen++;
                maybe_gap();
                case (ph)
                    PH_FILL:    phase_done = n_phase >= 120;
                    PH_EXHAUST: phase_done = no_slab_seen >= 3 || n_phase >= 320;
                    PH_DRAIN:   phase_done = n_phase >= 150;
                    default:    phase_done = n_phase >= 100;
                endcase
            end
            if (p == 2) begin
                // sender goes silent until every response is back
                req_ch.valid <= 1'b0;
                do @(posedge i_clk); while (expected_grants.size() != 0);
            end
            p++;
        end

        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (expected_grants.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Response side: random stall bursts plus one long hold
    initial begin
        int stall_left;
        bit hold_done;
        stall_left   = 0;
        hold_done    = 1'b0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else if (hold_request && !hold_done) begin
                hold_done     = 1'b1;
                stall_left    = LONG_HOLD;
                rsp_ch.ready <= 1'b0;
            end else if (gaps_on && !quiet && $urandom_range(0, 5) == 0) begin
                stall_left    = $urandom_range(0, 6);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Response check
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (expected_grants.size() == 0) begin
                $error("unexpected response: status %0d slab %0d slot %0d",
                       rsp_ch.status, rsp_ch.granted_slab, rsp_ch.granted_slot);
                mismatch_count++;
            end else begin
                want_now = expected_grants.pop_front();
                if (rsp_ch.status !== want_now.status) begin
                    $error("status: expected %0d, got %0d", want_now.status, rsp_ch.status);
                    mismatch_count++;
                end
                if (rsp_ch.granted_slab !== want_now.slab) begin
                    $error("granted_slab: expected %0d, got %0d",
                           want_now.slab, rsp_ch.granted_slab);
                    mismatch_count++;
                end
                if (rsp_ch.granted_slot !== want_now.slot) begin
                    $error("granted_slot: expected %0d, got %0d",
                           want_now.slot, rsp_ch.granted_slot);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
